FILE: rtl/bew_pkg.sv
// Shared types, register codes, reset values and mask tables for the binary erosion fit window.
package bew_pkg;

    // Defaults for the size parameters of the top level.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_RADIUS_DEF = 5;

    // Fixed field widths.
    localparam int PIXEL_W    = 8;
    localparam int MASK_W     = 3;
    localparam int RAD_W      = 3;
    localparam int DIM_W      = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd31;
    localparam logic [MASK_W-1:0]  MASK_RESET      = 3'd0;
    localparam logic [DIM_W-1:0]   DIM_RESET       = 11'd1024;

    // Structuring element codes.
    localparam logic [MASK_W-1:0] MASK_CROSS3   = 3'd0;
    localparam logic [MASK_W-1:0] MASK_CROSS5   = 3'd1;
    localparam logic [MASK_W-1:0] MASK_SQUARE3  = 3'd2;
    localparam logic [MASK_W-1:0] MASK_SQUARE5  = 3'd3;
    localparam logic [MASK_W-1:0] MASK_SQUARE7  = 3'd4;
    localparam logic [MASK_W-1:0] MASK_SQUARE9  = 3'd5;
    localparam logic [MASK_W-1:0] MASK_SQUARE11 = 3'd6;

    // One input request: a source pixel or a flush item.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               padding;
    } pix_req_t;

    // One result request.
    typedef struct packed {
        logic fit;
        logic last;
    } res_req_t;

    // Control from the sequencer to the window stage.
    typedef struct packed {
        logic shift;
        logic load;
        logic square;
    } fit_ctrl_t;

    // Radius of the structuring element; the unused code behaves as the largest square.
    function automatic logic [RAD_W-1:0] mask_radius(input logic [MASK_W-1:0] kind);
        logic [RAD_W-1:0] rad;
        case (kind)
            MASK_CROSS3:   rad = 3'd1;
            MASK_CROSS5:   rad = 3'd2;
            MASK_SQUARE3:  rad = 3'd1;
            MASK_SQUARE5:  rad = 3'd2;
            MASK_SQUARE7:  rad = 3'd3;
            MASK_SQUARE9:  rad = 3'd4;
            MASK_SQUARE11: rad = 3'd5;
            default:       rad = 3'd5;
        endcase
        return rad;
    endfunction

    function automatic logic mask_is_square(input logic [MASK_W-1:0] kind);
        return (kind != MASK_CROSS3) && (kind != MASK_CROSS5);
    endfunction

endpackage

FILE: rtl/bew_line_store.sv
// Column line store: one word of foreground bits from the rows above, per image column.
module bew_line_store #(
    parameter int DEPTH  = bew_pkg::MAX_WIDTH_DEF,
    parameter int DATA_W = 2 * bew_pkg::MAX_RADIUS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] line_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // A write to the address being read is forwarded, so a one-column image still works.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/bew_fit_window.sv
// Square window of foreground bits and the fit test of the structuring element over it.
module bew_fit_window #(
    parameter int MAX_RADIUS = bew_pkg::MAX_RADIUS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bew_pkg::fit_ctrl_t    ctrl,
    input  logic [2*MAX_RADIUS:0] col_bits,
    input  logic [2*MAX_RADIUS:0] row_en,
    input  logic [2*MAX_RADIUS:0] col_en,
    output logic                  fit
);

    localparam int WIN = 2 * MAX_RADIUS + 1;

    // win_reg[j] is one image column; bit k holds the row k rows above the newest one.
    logic [WIN-1:0] win_reg [WIN];
    logic [WIN-1:0] row_en_reg;
    logic [WIN-1:0] col_en_reg;
    logic           square_reg;
    logic           fit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                win_reg[j] <= '0;
            end
            row_en_reg <= '0;
            col_en_reg <= '0;
            square_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                for (int j = 0; j < WIN - 1; j++)
                begin
                    win_reg[j] <= win_reg[j+1];
                end
                win_reg[WIN-1] <= col_bits;
            end
            if (ctrl.load)
            begin
                row_en_reg <= row_en;
                col_en_reg <= col_en;
                square_reg <= ctrl.square;
            end
        end
    end

    // Every bit under the clipped element must be foreground.
    always_comb
    begin
        fit_ok = 1'b1;
        for (int ri = 0; ri < WIN; ri++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                if ((square_reg ? (row_en_reg[ri] && col_en_reg[j])
                                : ((row_en_reg[ri] && (j == MAX_RADIUS)) ||
                                   (col_en_reg[j] && (ri == MAX_RADIUS))))
                    && !win_reg[j][WIN-1-ri])
                begin
                    fit_ok = 1'b0;
                end
            end
        end
    end

    assign fit = fit_ok;

endmodule

FILE: rtl/binary_erosion_fit_window_unit.sv
// Top level of the binary erosion fit window: sequencing, configuration and result register.
//
// Pixels arrive in raster order, one request per clock when neither side stalls, and each
// is reduced to a foreground bit (above the background threshold). The bit is merged with the
// 2*MAX_RADIUS bits of the same column from the rows above, held in a line store of MAX_WIDTH
// words that is read one column ahead, and the resulting column is shifted into a square window.
// The result for a centre pixel is produced on the request that arrives
// D = MAX_RADIUS*width + MAX_RADIUS requests after it, and then leaves through
// a window stage and an output register, so after the last pixel of a frame the host sends D
// padding requests to drain the final results; a padding request inside the frame is simply
// absorbed. The element (cross of radius 1 or 2, square of radius 1 to 5) is clipped at the
// frame edges, so window bits outside the image never matter; for that reason the line store has
// no clearing pass and the block is ready straight out of reset. Throughput is one request per
// cycle while the result side does not stall, as a column takes one read and one write of the
// line store. A write to the width or height register restarts the frame; registers are to be
// written while the block is idle. The result carrying last marks the final pixel, after which
// the next request starts a fresh frame.
module binary_erosion_fit_window_unit #(
    parameter int MAX_WIDTH  = bew_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bew_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = bew_pkg::MAX_RADIUS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pixel requests
    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  bew_pkg::pix_req_t                    pix,
    // result requests
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output bew_pkg::res_req_t                    res,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [bew_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [bew_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int WIN    = 2 * MAX_RADIUS + 1;
    localparam int STW    = 2 * MAX_RADIUS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int LEAD_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    // Configuration registers.
    logic [bew_pkg::PIXEL_W-1:0] thr_reg;
    logic [bew_pkg::MASK_W-1:0]  mask_reg;
    logic [bew_pkg::DIM_W-1:0]   width_reg;
    logic [bew_pkg::DIM_W-1:0]   height_reg;

    // Raster counters: input position, centre of the next result, and the lead between them.
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [HW-1:0]     in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [LEAD_W-1:0] lead_reg, lead_next;

    // Window stage and output register.
    logic              s1_vld_reg;
    logic              s1_last_reg;
    logic              res_valid_reg;
    bew_pkg::res_req_t res_reg;

    logic [WW-1:0]              eff_w;
    logic [HW-1:0]              eff_h;
    logic [LEAD_W-1:0]          delay;
    logic [bew_pkg::RAD_W-1:0]  kind_rad;
    logic [bew_pkg::RAD_W-1:0]  rad;
    logic                       in_frame;
    logic                       acc;
    logic                       adv;
    logic                       emit;
    logic                       col_wrap;
    logic                       last_now;
    logic                       cfg_restart;
    logic                       restart;
    logic                       out_free;
    logic                       s1_free;
    logic                       fg;
    logic [STW-1:0]             above_bits;
    logic [WIN-1:0]             col_bits;
    logic [WIN-1:0]             row_en;
    logic [WIN-1:0]             col_en;
    logic                       fit;
    bew_pkg::fit_ctrl_t         ctrl;

    // Frame size as used: zero reads as one, oversize saturates.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(height_reg);
        end
    end

    assign delay = LEAD_W'(eff_w) * LEAD_W'(MAX_RADIUS) + LEAD_W'(MAX_RADIUS);

    assign kind_rad = bew_pkg::mask_radius(mask_reg);
    assign rad      = (32'(kind_rad) > 32'(MAX_RADIUS)) ? bew_pkg::RAD_W'(MAX_RADIUS) : kind_rad;

    // Handshake: the window stage frees up whenever its result moves into the output register.
    assign out_free  = !res_valid_reg || !res_stall;
    assign s1_free   = !s1_vld_reg || out_free;
    assign pix_stall = !s1_free;

    assign acc      = pix_valid && !pix_stall;
    assign in_frame = in_row_reg < eff_h;
    // A padding request inside the frame is taken but does not move the raster.
    assign adv      = acc && !(in_frame && pix.padding);
    assign emit     = lead_reg == delay;
    assign col_wrap = (WW'(in_col_reg) + WW'(1)) == eff_w;
    assign last_now = ((WW'(out_col_reg) + WW'(1)) == eff_w) &&
                      ((HW'(out_row_reg) + HW'(1)) == eff_h);

    assign cfg_restart = cfg_we && ((cfg_addr == bew_pkg::REG_WIDTH) ||
                                    (cfg_addr == bew_pkg::REG_HEIGHT));
    assign restart     = cfg_restart || (adv && emit && last_now);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lead_next    = '0;
        end
        else if (adv)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                if (in_frame)
                begin
                    in_row_next = in_row_reg + HW'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            if (emit)
            begin
                if ((WW'(out_col_reg) + WW'(1)) == eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            else
            begin
                lead_next = lead_reg + LEAD_W'(1);
            end
        end
    end

    // Configuration writes and the control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= bew_pkg::THRESHOLD_RESET;
            mask_reg      <= bew_pkg::MASK_RESET;
            width_reg     <= bew_pkg::DIM_RESET;
            height_reg    <= bew_pkg::DIM_RESET;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            lead_reg      <= '0;
            s1_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    bew_pkg::REG_THRESHOLD: thr_reg    <= cfg_wdata[bew_pkg::PIXEL_W-1:0];
                    bew_pkg::REG_MASK:      mask_reg   <= cfg_wdata[bew_pkg::MASK_W-1:0];
                    bew_pkg::REG_WIDTH:     width_reg  <= cfg_wdata;
                    bew_pkg::REG_HEIGHT:    height_reg <= cfg_wdata;
                    default:                ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lead_reg    <= lead_next;
            if (s1_free)
            begin
                s1_vld_reg <= adv && emit;
            end
            if (out_free)
            begin
                res_valid_reg <= s1_vld_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            s1_last_reg <= last_now;
        end
        if (out_free)
        begin
            res_reg.fit  <= fit;
            res_reg.last <= s1_last_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // New column: the current foreground bit below the stored bits of the rows above.
    // Flush requests past the frame carry background; they lie outside the image anyway.
    assign fg       = in_frame && (pix.pixel > thr_reg);
    assign col_bits = {above_bits, fg};

    bew_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (STW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (adv),
        .wr_addr (in_col_reg),
        .wr_data (col_bits[STW-1:0]),
        .rd_addr (in_col_next),
        .rd_data (above_bits)
    );

    // Rows and columns of the window that lie inside both the element and the frame.
    always_comb
    begin
        row_en = '0;
        col_en = '0;
        for (int i = 0; i < WIN; i++)
        begin
            if (i < MAX_RADIUS)
            begin
                row_en[i] = (32'(MAX_RADIUS - i) <= 32'(rad)) &&
                            (32'(out_row_reg) >= 32'(MAX_RADIUS - i));
                col_en[i] = (32'(MAX_RADIUS - i) <= 32'(rad)) &&
                            (32'(out_col_reg) >= 32'(MAX_RADIUS - i));
            end
            else
            begin
                row_en[i] = (32'(i - MAX_RADIUS) <= 32'(rad)) &&
                            ((32'(out_row_reg) + 32'(i - MAX_RADIUS)) < 32'(eff_h));
                col_en[i] = (32'(i - MAX_RADIUS) <= 32'(rad)) &&
                            ((32'(out_col_reg) + 32'(i - MAX_RADIUS)) < 32'(eff_w));
            end
        end
    end

    assign ctrl.shift  = adv;
    assign ctrl.load   = adv && emit;
    assign ctrl.square = bew_pkg::mask_is_square(mask_reg);

    bew_fit_window #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_fit_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .col_bits (col_bits),
        .row_en   (row_en),
        .col_en   (col_en),
        .fit      (fit)
    );

    // The lead between input and result never overshoots the window delay.
    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg <= delay)
        else $error("lead counter beyond window delay");

    // The input and output columns always lie inside the frame width.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(in_col_reg) < eff_w) && (WW'(out_col_reg) < eff_w))
        else $error("column counter outside frame width");

    // The final result of a frame returns every raster counter to the origin.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && emit && last_now) |=>
            (in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 &&
             out_row_reg == '0 && lead_reg == '0))
        else $error("counters not cleared after frame end");

    // With nothing waiting in the window stage, a request is never refused.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_vld_reg |-> !pix_stall)
        else $error("stall raised with empty window stage");

endmodule

FILE: test/binary_erosion_fit_window_checker.sv
// Scoreboard for the binary erosion fit window: predicts each fit result and checks the DUT.
`timescale 1ns / 1ps

module binary_erosion_fit_window_checker #(
    parameter int MAX_WIDTH  = bew_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bew_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = bew_pkg::MAX_RADIUS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    input  logic                           pix_stall,
    input  bew_pkg::pix_req_t              pix,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  bew_pkg::res_req_t              res,
    input  logic                           cfg_we,
    input  logic [bew_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [bew_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             outstanding,
    output int                             results_checked
);

    localparam int RING_BITS = (2 * MAX_RADIUS + 2) * MAX_WIDTH;

    // Foreground bits of the recent rows; only positions written in the current frame are read.
    bit                            fg_ring [0:RING_BITS-1];
    logic [bew_pkg::PIXEL_W-1:0]   thr_cfg;
    logic [bew_pkg::MASK_W-1:0]    mask_cfg;
    logic [bew_pkg::DIM_W-1:0]     width_cfg;
    logic [bew_pkg::DIM_W-1:0]     height_cfg;
    int unsigned                   in_row, in_col, out_row, out_col;
    bew_pkg::res_req_t             fit_expected_q [$];

    function automatic int unsigned eff_dim(input logic [bew_pkg::DIM_W-1:0] word,
                                            input int unsigned cap);
        if (word == 0)
            return 1;
        if (word > cap)
            return cap;
        return word;
    endfunction

    function automatic int unsigned elem_radius(input logic [bew_pkg::MASK_W-1:0] kind);
        int unsigned rad;
        case (kind)
            bew_pkg::MASK_CROSS3, bew_pkg::MASK_SQUARE3: rad = 1;
            bew_pkg::MASK_CROSS5, bew_pkg::MASK_SQUARE5: rad = 2;
            bew_pkg::MASK_SQUARE7:                       rad = 3;
            bew_pkg::MASK_SQUARE9:                       rad = 4;
            default:                                     rad = 5;
        endcase
        if (rad > MAX_RADIUS)
            rad = MAX_RADIUS;
        return rad;
    endfunction

    function automatic bit fg_at(input int unsigned r, input int unsigned c, input int unsigned w);
        return fg_ring[(r * w + c) % RING_BITS];
    endfunction

    // Clipped window: anything outside the frame is simply not looked at.
    function automatic bit window_fits(input int unsigned row, input int unsigned col,
                                       input int unsigned w, input int unsigned h);
        int unsigned rad, r0, r1, c0, c1;
        bit          square;
        rad    = elem_radius(mask_cfg);
        square = (mask_cfg != bew_pkg::MASK_CROSS3) && (mask_cfg != bew_pkg::MASK_CROSS5);
        r0 = (row >= rad) ? row - rad : 0;
        c0 = (col >= rad) ? col - rad : 0;
        r1 = (row + rad > h - 1) ? h - 1 : row + rad;
        c1 = (col + rad > w - 1) ? w - 1 : col + rad;
        if (square)
        begin
            for (int unsigned r = r0; r <= r1; r++)
                for (int unsigned c = c0; c <= c1; c++)
                    if (!fg_at(r, c, w))
                        return 1'b0;
        end
        else
        begin
            for (int unsigned r = r0; r <= r1; r++)
                if (!fg_at(r, col, w))
                    return 1'b0;
            for (int unsigned c = c0; c <= c1; c++)
                if (!fg_at(row, c, w))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, what);
        fail_count++;
    endtask

    task automatic restart_frame();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endtask

    task automatic apply_write(input logic [bew_pkg::CFG_IDX_W-1:0] idx,
                               input logic [bew_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bew_pkg::REG_THRESHOLD: thr_cfg = data[bew_pkg::PIXEL_W-1:0];
            bew_pkg::REG_MASK:      mask_cfg = data[bew_pkg::MASK_W-1:0];
            bew_pkg::REG_WIDTH:
            begin
                width_cfg = data[bew_pkg::DIM_W-1:0];
                restart_frame();
            end
            bew_pkg::REG_HEIGHT:
            begin
                height_cfg = data[bew_pkg::DIM_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endtask

    // One accepted request: store its foreground bit, then emit the result that has become due.
    task automatic absorb_request(input bew_pkg::pix_req_t req);
        int unsigned       w, h, frame_px, n, o, lag;
        bew_pkg::res_req_t due;
        w        = eff_dim(width_cfg, MAX_WIDTH);
        h        = eff_dim(height_cfg, MAX_HEIGHT);
        frame_px = w * h;
        n        = in_row * w + in_col;
        lag      = MAX_RADIUS * w + MAX_RADIUS;
        if (n < frame_px)
        begin
            if (req.padding)
                return;
            fg_ring[n % RING_BITS] = (req.pixel > thr_cfg);
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        o = out_row * w + out_col;
        if (n < o + lag)
            return;
        due.fit  = window_fits(out_row, out_col, w, h);
        due.last = (o == frame_px - 1);
        fit_expected_q.push_back(due);
        if (due.last)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic compare_result(input bew_pkg::res_req_t got);
        bew_pkg::res_req_t want;
        if (fit_expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result fit=%0b last=%0b", got.fit, got.last));
        end
        else
        begin
            want = fit_expected_q.pop_front();
            if (got.fit !== want.fit)
                report_mismatch($sformatf("fit %0b, expected %0b", got.fit, want.fit));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        end
        results_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_cfg         = bew_pkg::THRESHOLD_RESET;
            mask_cfg        = bew_pkg::MASK_RESET;
            width_cfg       = bew_pkg::DIM_RESET;
            height_cfg      = bew_pkg::DIM_RESET;
            restart_frame();
            fit_expected_q.delete();
            fail_count      = 0;
            results_checked = 0;
            outstanding     = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                compare_result(res);
            if (cfg_we)
                apply_write(cfg_addr, cfg_wdata);
            if (pix_valid && !pix_stall)
                absorb_request(pix);
            outstanding = fit_expected_q.size();
        end
    end

endmodule

FILE: test/tb_binary_erosion_fit_window_unit.sv
// Testbench top for the binary erosion fit window: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb_binary_erosion_fit_window_unit;

    localparam int MAX_WIDTH    = bew_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT   = bew_pkg::MAX_HEIGHT_DEF;
    localparam int MAX_RADIUS   = bew_pkg::MAX_RADIUS_DEF;
    // The mask code with no name of its own; the block treats it as the largest square.
    localparam logic [bew_pkg::MASK_W-1:0] MASK_SPARE = 3'd7;
    // Results leave via the window stage and the output register; this leaves a margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 1000;
    // Request count at which the random part stops starting new frames.
    localparam int RANDOM_ITEMS  = 680;

    typedef logic [bew_pkg::PIXEL_W-1:0] pixel_t;
    typedef logic [bew_pkg::MASK_W-1:0]  mask_t;
    typedef logic [bew_pkg::DIM_W-1:0]   dim_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            pix_valid = 1'b0;
    logic                            pix_stall;
    bew_pkg::pix_req_t               pix = '0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    bew_pkg::res_req_t               res;
    logic                            cfg_we = 1'b0;
    logic [bew_pkg::CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [bew_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    int                              fail_count;
    int                              outstanding;
    int                              results_checked;

    // Stimulus bookkeeping: the current threshold shapes the pixel values, the current
    // frame size sets how many pixels and flush requests a frame needs.
    pixel_t                          cur_thr = bew_pkg::THRESHOLD_RESET;
    int unsigned                     cur_w = MAX_WIDTH;
    int unsigned                     cur_h = MAX_HEIGHT;
    int unsigned                     burst_left = 0;
    int unsigned                     frames_done = 0;
    int unsigned                     partials_done = 0;
    int unsigned                     px_sent = 0;
    int unsigned                     flush_sent = 0;
    int unsigned                     pad_sent = 0;
    int unsigned                     idle_cycles = 0;
    stall_mode_t                     stall_mode = STALL_NONE;
    int unsigned                     stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    binary_erosion_fit_window_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    binary_erosion_fit_window_checker fit_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .pix_valid       (pix_valid),
        .pix_stall       (pix_stall),
        .pix             (pix),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // The result side switches its behaviour at random between free running, light
    // random back-pressure, a fixed two-in-three pattern, or heavy random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_mode <= STALL_NONE;
            stall_left <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                stall_left <= $urandom_range(20, 300);
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                STALL_LIGHT:    res_stall <= ($urandom_range(0, 99) < 25);
                STALL_PERIODIC: res_stall <= ((stall_left % 3) != 0);
                STALL_HEAVY:    res_stall <= ($urandom_range(0, 99) < 70);
                default:        res_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog: any cycle with no request accepted on either side and no register write
    // counts towards the limit.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int unsigned frame_dim(input dim_t word, input int unsigned cap);
        if (word == 0)
            return 1;
        if (word > cap)
            return cap;
        return word;
    endfunction

    // Pixels are biased towards foreground so that the larger squares still fit now and then;
    // one in ten is fully random so every bit of the value is exercised.
    function automatic pixel_t make_pixel(input int unsigned fg_pct);
        if ($urandom_range(0, 9) == 0)
            return pixel_t'($urandom);
        if ($urandom_range(0, 99) < fg_pct && cur_thr != 8'hFF)
            return pixel_t'($urandom_range(cur_thr + 1, 255));
        return pixel_t'($urandom_range(0, cur_thr));
    endfunction

    // Sends one request, idling between bursts. A long burst now and then gives stretches
    // with no gaps at all.
    task automatic send_request(input pixel_t value, input logic pad);
        bew_pkg::pix_req_t item;
        if (burst_left == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        item.pixel   = value;
        item.padding = pad;
        pix_valid <= 1'b1;
        pix       <= item;
        do @(posedge clk); while (pix_stall);
        burst_left--;
    endtask

    // Holds the sender back until the scoreboard has nothing outstanding. The count is
    // sampled on the falling edge so it is settled.
    task automatic wait_drained();
        pix_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [bew_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bew_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Register writes only happen with the block drained. The unused upper bits of the
    // threshold and mask words carry random values, which the block must ignore.
    task automatic configure(input pixel_t thr, input mask_t kind,
                             input dim_t w_word, input dim_t h_word, input bit dims);
        logic [31:0] rnd_thr;
        logic [31:0] rnd_kind;
        rnd_thr  = $urandom;
        rnd_kind = $urandom;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(bew_pkg::REG_THRESHOLD,
                  {rnd_thr[bew_pkg::CFG_DATA_W-bew_pkg::PIXEL_W-1:0], thr});
        write_reg(bew_pkg::REG_MASK,
                  {rnd_kind[bew_pkg::CFG_DATA_W-bew_pkg::MASK_W-1:0], kind});
        if (dims)
        begin
            write_reg(bew_pkg::REG_WIDTH, w_word);
            write_reg(bew_pkg::REG_HEIGHT, h_word);
            cur_w = frame_dim(w_word, MAX_WIDTH);
            cur_h = frame_dim(h_word, MAX_HEIGHT);
        end
        cfg_we  <= 1'b0;
        cur_thr = thr;
    endtask

    // One whole frame: the pixels with occasional padding requests slipped in (which the
    // block absorbs), then the flush requests that push out the trailing results. Flush
    // requests carry random pixels and a random padding flag, since both are ignored there.
    task automatic run_frame(input int unsigned fg_pct, input int unsigned pad_pct, input bit hold);
        int unsigned frame_px, flush_n;
        frame_px = cur_w * cur_h;
        flush_n  = MAX_RADIUS * cur_w + MAX_RADIUS;
        for (int unsigned i = 0; i < frame_px; i++)
        begin
            if (hold && i == frame_px / 2)
                wait_drained();
            if ($urandom_range(0, 99) < pad_pct)
            begin
                send_request(pixel_t'($urandom), 1'b1);
                pad_sent++;
            end
            send_request(make_pixel(fg_pct), 1'b0);
            px_sent++;
        end
        for (int unsigned i = 0; i < flush_n; i++)
        begin
            send_request(pixel_t'($urandom), $urandom_range(0, 3) != 0);
            flush_sent++;
        end
        frames_done++;
    endtask

    // The start of a frame only; the next size write restarts the block mid-frame.
    task automatic run_partial(input int unsigned count, input int unsigned fg_pct);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_request(make_pixel(fg_pct), 1'b0);
            px_sent++;
        end
        partials_done++;
    endtask

    task automatic run_phase(input pixel_t thr, input mask_t kind,
                             input dim_t w_word, input dim_t h_word,
                             input bit dims, input int unsigned fg_pct,
                             input int unsigned pad_pct, input bit hold);
        configure(thr, kind, w_word, h_word, dims);
        run_frame(fg_pct, pad_pct, hold);
    endtask

    initial
    begin
        int unsigned fg, pad;
        pixel_t      thr;
        dim_t        w_word, h_word;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every mask including the spare code, the threshold extremes, zero
        // sizes that count as one, padding inside the frame, a pause mid-frame, a drain before
        // each reconfiguration, and a second frame started straight after the last result.
        run_phase(8'd31,  bew_pkg::MASK_CROSS3,   11'd3,  11'd3, 1'b1, 90, 15, 1'b1);
        run_phase(8'd0,   bew_pkg::MASK_CROSS5,   11'd5,  11'd4, 1'b1, 95, 10, 1'b0);
        run_phase(8'd255, bew_pkg::MASK_SQUARE3,  11'd2,  11'd2, 1'b1, 100, 0, 1'b0);
        run_phase(8'd128, bew_pkg::MASK_SQUARE5,  11'd0,  11'd5, 1'b1, 90, 10, 1'b0);
        run_phase(8'd200, bew_pkg::MASK_SQUARE7,  11'd6,  11'd0, 1'b1, 90, 0, 1'b0);
        run_phase(8'd10,  bew_pkg::MASK_SQUARE9,  11'd7,  11'd7, 1'b1, 100, 5, 1'b0);
        run_phase(8'd50,  bew_pkg::MASK_SQUARE11, 11'd12, 11'd8, 1'b1, 100, 5, 1'b1);
        run_phase(8'd50,  MASK_SPARE,             11'd8,  11'd8, 1'b1, 99, 0, 1'b0);
        run_frame(97, 5, 1'b0);

        // Random part: small frames with mixed foreground density, sometimes keeping the
        // previous size, sometimes running a frame back to back with no reconfiguration.
        while (px_sent + flush_sent + pad_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:       fg = 60;
                1:       fg = 90;
                2:       fg = 97;
                default: fg = 100;
            endcase
            pad = $urandom_range(0, 10);
            case ($urandom_range(0, 9))
                0:       thr = 8'd0;
                1:       thr = 8'd255;
                default: thr = pixel_t'($urandom_range(1, 254));
            endcase
            w_word = ($urandom_range(0, 9) == 0) ? 11'd0 : dim_t'($urandom_range(1, 12));
            h_word = ($urandom_range(0, 9) == 0) ? 11'd0 : dim_t'($urandom_range(1, 12));
            if ($urandom_range(0, 5) == 0)
                run_frame(fg, pad, $urandom_range(0, 3) == 0);
            else
                run_phase(thr, mask_t'($urandom_range(0, 7)), w_word, h_word,
                          $urandom_range(0, 4) != 0, fg, pad, $urandom_range(0, 3) == 0);
        end

        // Sizes above the maximum, which saturate; each of these frames is cut short by the
        // next size write, and a complete frame afterwards shows the restart was clean.
        configure(8'd70, bew_pkg::MASK_CROSS5, 11'd1, 11'd2047, 1'b1);
        run_partial(40, 95);
        configure(8'd70, bew_pkg::MASK_SQUARE3, 11'd2047, 11'd1, 1'b1);
        run_partial(30, 95);
        run_phase(8'd60, bew_pkg::MASK_SQUARE5, 11'd4, 11'd3, 1'b1, 95, 5, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d frames and %0d cut-short frames: %0d pixels, %0d flush and %0d padding.",
                 frames_done, partials_done, px_sent, flush_sent, pad_sent);
        $display("Checked %0d fit results against the prediction, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bew_pkg.sv
rtl/bew_line_store.sv
rtl/bew_fit_window.sv
rtl/binary_erosion_fit_window_unit.sv
test/binary_erosion_fit_window_checker.sv
test/tb_binary_erosion_fit_window_unit.sv
